@@ design/hds_pkg.sv @@
`timescale 1ns / 1ps
package hds_pkg;

    localparam int MAX_BINS    = 256;
    localparam int FRAC_BITS   = 16;
    localparam int LOG_ENTRIES = 256;
    localparam int LOG_IDX_W   = $clog2(LOG_ENTRIES);
    localparam int LOG_FB      = 24;
    localparam int BIN_W       = FRAC_BITS + 1;
    localparam int LOG_IN_W    = BIN_W + 1;
    localparam int LOG_K_W     = $clog2(LOG_IN_W);
    localparam int LOG_OUT_W   = LOG_K_W + LOG_FB;
    localparam int CNT_W       = $clog2(MAX_BINS + 1);

    localparam logic [BIN_W-1:0] ONE_Q    = BIN_W'(1) << FRAC_BITS;
    localparam logic [23:0]      LN2_Q24  = 24'd11629080;
    localparam logic [63:0]      HALF_LOG = 64'd1 << (LOG_FB - 1);

    localparam logic [2:0] MODE_INTERSECT = 3'd0;
    localparam logic [2:0] MODE_LOGLIK    = 3'd1;
    localparam logic [2:0] MODE_CHISQ     = 3'd2;
    localparam logic [2:0] MODE_KL        = 3'd3;
    localparam logic [2:0] MODE_EUCLID    = 3'd4;
    localparam logic [2:0] MODE_ABSOLUTE  = 3'd5;
    localparam logic [2:0] MODE_COSINE    = 3'd6;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    typedef logic [LOG_ENTRIES-1:0][LOG_FB-1:0] log_rom_t;

    typedef struct packed {
        logic        start;
        logic [63:0] rem_init;
        logic [63:0] num_init;
        logic [63:0] den;
        logic [6:0]  iters;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    // log2(1 + idx/entries) in Q.24 by repeated squaring
    function automatic log_rom_t build_log_rom();
        log_rom_t rom;
        logic [63:0] y;
        logic [LOG_FB-1:0] r;
        for (int idx = 0; idx < LOG_ENTRIES; idx++)
        begin
            y = ((64'(LOG_ENTRIES) + 64'(idx)) << 30) / LOG_ENTRIES;
            r = '0;
            for (int i = LOG_FB - 1; i >= 0; i--)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31))
                begin
                    y = y >> 1;
                    r[i] = 1'b1;
                end
            end
            rom[idx] = r;
        end
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

@@ design/histogram_distance_scorer.sv @@
`timescale 1ns / 1ps
// Histogram distance scorer. Feed one expected/observed bin pair per transfer
// (Q1.16, 65536 = 1.0, tlast on the final bin); one score per histogram comes
// out, clipped to [0,1] in Q.16, with tuser flagging unnormalized input, mode 7
// or a zero intersection divisor (score 0 then). Bins are processed one at a
// time through a shared 32x32 multiplier, a restoring divider, a bit-pair
// square-root unit and a log2 table; s_axis_tready is low while a bin is in
// work. Per bin, Euclidean and cosine add a product term, log-likelihood one
// log pass, Jeffrey two log passes and chi-squared a 33-step division. The
// final bin adds a division for intersection, a 49-step division plus 32-step
// root for Euclidean, and two roots and a 30-step division for cosine.
// metric_mode sits at byte address 0, norm_tolerance at 4; write only when idle.
module histogram_distance_scorer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // expected_bin[16:0], observed_bin[33:17], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // score[16:0], zero pad
    output logic        m_axis_tuser,   // input_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hds_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQE   = 5'd1;
    localparam logic [4:0] S_SQO   = 5'd2;
    localparam logic [4:0] S_TERM  = 5'd3;
    localparam logic [4:0] S_PTERM = 5'd4;
    localparam logic [4:0] S_LGN   = 5'd5;
    localparam logic [4:0] S_LGD   = 5'd6;
    localparam logic [4:0] S_LNM   = 5'd7;
    localparam logic [4:0] S_LNR   = 5'd8;
    localparam logic [4:0] S_LNV   = 5'd9;
    localparam logic [4:0] S_LNT   = 5'd10;
    localparam logic [4:0] S_CHID  = 5'd11;
    localparam logic [4:0] S_CHIW  = 5'd12;
    localparam logic [4:0] S_ACC   = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_FDIVW = 5'd15;
    localparam logic [4:0] S_ESQW  = 5'd16;
    localparam logic [4:0] S_CSQ1  = 5'd17;
    localparam logic [4:0] S_CSQ2  = 5'd18;
    localparam logic [4:0] S_COSM  = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    logic [4:0]             state_reg, state_next;
    logic [2:0]             mode_reg;
    logic [15:0]            tol_reg;
    logic [BIN_W-1:0]       e_reg, e_next, o_reg, o_next;
    logic                   last_reg, last_next;
    logic [47:0]            acc_reg, acc_next;
    logic [39:0]            esum_reg, esum_next, osum_reg, osum_next;
    logic [47:0]            ee_reg, ee_next, oo_reg, oo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [63:0]            prod_reg;
    logic [47:0]            term_reg, term_next;
    logic [LOG_OUT_W-1:0]   lgn_reg, lgn_next, mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [29:0]            lnm_reg, lnm_next;
    logic signed [25:0]     net_reg, net_next;
    logic                   side_reg, side_next;
    logic [31:0]            root_reg, root_next;
    logic [BIN_W-1:0]       score_reg, score_next;
    logic                   err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]       out_score_reg, out_score_next;
    logic                   out_err_reg, out_err_next;

    logic [BIN_W-1:0]       e_in, o_in, diff;
    logic [BIN_W:0]         bsum;
    logic [31:0]            mul_a, mul_b;
    logic [LOG_IN_W-1:0]    log_x;
    logic [LOG_OUT_W-1:0]   log_y;
    logic [BIN_W-1:0]       w_v;
    logic [LOG_IN_W-1:0]    w_num, w_den;
    logic [63:0]            rnd;
    logic [22:0]            t_val;
    logic signed [25:0]     net_sum;
    logic [39:0]            mx;
    logic                   e_ok, o_ok;
    logic [48:0]            eu_num;
    logic                   cfg_wr;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    sqrt_req_t              sqrt_req;
    sqrt_rsp_t              sqrt_rsp;

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[48] ? {48{1'b1}} : t[47:0];
    endfunction

    function automatic logic [39:0] sat40(input logic [39:0] a, input logic [BIN_W-1:0] b);
        logic [40:0] t;
        t = {1'b0, a} + 41'(b);
        return t[40] ? {40{1'b1}} : t[39:0];
    endfunction

    function automatic logic sum_ok(input logic [39:0] s, input logic [15:0] tol);
        logic [39:0] dv;
        dv = (s > 40'(ONE_Q)) ? s - 40'(ONE_Q) : 40'(ONE_Q) - s;
        return dv <= 40'(tol);
    endfunction

    function automatic logic [BIN_W-1:0] clip_one(input logic [63:0] v);
        return (v > 64'(ONE_Q)) ? ONE_Q : v[BIN_W-1:0];
    endfunction

    hds_log2 u_log2
    (
        .x (log_x),
        .y (log_y)
    );

    hds_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hds_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_MODE: prdata = {29'd0, mode_reg};
            REG_TOL:  prdata = {16'd0, tol_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COSINE;
            tol_reg  <= 16'd16;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MODE)
            begin
                mode_reg <= pwdata[2:0];
            end
            else
            begin
                tol_reg <= pwdata[15:0];
            end
        end
    end

    // input bins saturate at 1.0
    assign e_in = (s_axis_tdata[16:0] > ONE_Q) ? ONE_Q : s_axis_tdata[16:0];
    assign o_in = (s_axis_tdata[33:17] > ONE_Q) ? ONE_Q : s_axis_tdata[33:17];
    assign diff = (e_reg > o_reg) ? e_reg - o_reg : o_reg - e_reg;
    assign bsum = {1'b0, e_reg} + {1'b0, o_reg};

    // operands of the current log pass
    always_comb
    begin
        if (mode_reg == MODE_LOGLIK)
        begin
            w_v   = o_reg;
            w_num = LOG_IN_W'(ONE_Q);
            w_den = LOG_IN_W'(e_reg);
        end
        else if (!side_reg)
        begin
            w_v   = e_reg;
            w_num = {e_reg, 1'b0};
            w_den = bsum;
        end
        else
        begin
            w_v   = o_reg;
            w_num = {o_reg, 1'b0};
            w_den = bsum;
        end
    end

    assign log_x   = (state_reg == S_LGN) ? w_num : w_den;
    assign rnd     = prod_reg + HALF_LOG;
    assign t_val   = rnd[46:24];
    assign net_sum = neg_reg ? net_reg - 26'(t_val) : net_reg + 26'(t_val);
    assign mx      = (esum_reg > osum_reg) ? esum_reg : osum_reg;
    assign e_ok    = sum_ok(esum_reg, tol_reg);
    assign o_ok    = sum_ok(osum_reg, tol_reg);
    assign eu_num  = {1'b0, acc_reg} + 49'(cnt_reg >> 1);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQE:
            begin
                mul_a = 32'(e_reg);
                mul_b = 32'(e_reg);
            end
            S_SQO:
            begin
                mul_a = 32'(o_reg);
                mul_b = 32'(o_reg);
            end
            S_TERM:
            begin
                if (mode_reg == MODE_COSINE)
                begin
                    mul_a = 32'(e_reg);
                    mul_b = 32'(o_reg);
                end
                else
                begin
                    mul_a = 32'(diff);
                    mul_b = 32'(diff);
                end
            end
            S_LNM:
            begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(LN2_Q24);
            end
            S_LNV:
            begin
                mul_a = 32'(w_v);
                mul_b = 32'(lnm_reg);
            end
            S_CSQ2:
            begin
                mul_a = root_reg;
                mul_b = sqrt_rsp.root;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        o_next         = o_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        esum_next      = esum_reg;
        osum_next      = osum_reg;
        ee_next        = ee_reg;
        oo_next        = oo_reg;
        cnt_next       = cnt_reg;
        term_next      = term_reg;
        lgn_next       = lgn_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        lnm_next       = lnm_reg;
        net_next       = net_reg;
        side_next      = side_reg;
        root_next      = root_reg;
        score_next     = score_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_score_next = out_score_reg;
        out_err_next   = out_err_reg;
        div_req        = '0;
        sqrt_req       = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    e_next     = e_in;
                    o_next     = o_in;
                    last_next  = s_axis_tlast;
                    state_next = S_SQE;
                end
            end
            S_SQE:
            begin
                state_next = S_SQO;
            end
            S_SQO:
            begin
                ee_next    = sat48(ee_reg, prod_reg[47:0]);
                state_next = S_TERM;
            end
            S_TERM:
            begin
                oo_next   = sat48(oo_reg, prod_reg[47:0]);
                esum_next = sat40(esum_reg, e_reg);
                osum_next = sat40(osum_reg, o_reg);
                if (cnt_reg < CNT_W'(MAX_BINS))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                term_next  = '0;
                net_next   = '0;
                side_next  = 1'b0;
                state_next = S_ACC;
                case (mode_reg)
                    MODE_INTERSECT: term_next = 48'((e_reg < o_reg) ? e_reg : o_reg);
                    MODE_ABSOLUTE:  term_next = 48'(diff);
                    MODE_EUCLID:    state_next = S_PTERM;
                    MODE_COSINE:    state_next = S_PTERM;
                    MODE_CHISQ:
                    begin
                        if (bsum != '0)
                        begin
                            state_next = S_CHID;
                        end
                    end
                    MODE_LOGLIK:
                    begin
                        if (e_reg != '0)
                        begin
                            state_next = S_LGN;
                        end
                    end
                    MODE_KL:
                    begin
                        if (bsum != '0)
                        begin
                            side_next  = (e_reg == '0);
                            state_next = S_LGN;
                        end
                    end
                    default: term_next = '0;
                endcase
            end
            S_PTERM:
            begin
                term_next  = prod_reg[47:0];
                state_next = S_ACC;
            end
            S_LGN:
            begin
                lgn_next   = log_y;
                state_next = S_LGD;
            end
            S_LGD:
            begin
                neg_next   = lgn_reg < log_y;
                mag_next   = (lgn_reg < log_y) ? log_y - lgn_reg : lgn_reg - log_y;
                state_next = S_LNM;
            end
            S_LNM:
            begin
                state_next = S_LNR;
            end
            S_LNR:
            begin
                lnm_next   = rnd[53:24];
                state_next = S_LNV;
            end
            S_LNV:
            begin
                state_next = S_LNT;
            end
            S_LNT:
            begin
                net_next = net_sum;
                if ((mode_reg == MODE_KL) && !side_reg && (o_reg != '0))
                begin
                    side_next  = 1'b1;
                    state_next = S_LGN;
                end
                else
                begin
                    term_next  = (net_sum > 26'sd0) ? 48'(net_sum) : 48'd0;
                    state_next = S_ACC;
                end
            end
            S_CHID:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.num_init = {prod_reg[32:0] + 33'(bsum >> 1), 31'd0};
                div_req.den      = 64'(bsum);
                div_req.iters    = 7'd33;
                state_next       = S_CHIW;
            end
            S_CHIW:
            begin
                if (div_rsp.done)
                begin
                    term_next  = div_rsp.quot[47:0];
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                acc_next   = sat48(acc_reg, term_reg);
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                score_next = '0;
                err_next   = 1'b0;
                state_next = S_DONE;
                if (!e_ok || !o_ok || (mode_reg > MODE_COSINE))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    case (mode_reg)
                        MODE_INTERSECT:
                        begin
                            if (mx == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else if (48'(mx) <= acc_reg)
                            begin
                                score_next = ONE_Q;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.rem_init = 64'(acc_reg);
                                div_req.num_init = '0;
                                div_req.den      = 64'(mx);
                                div_req.iters    = 7'(FRAC_BITS);
                                state_next       = S_FDIVW;
                            end
                        end
                        MODE_LOGLIK, MODE_KL:
                        begin
                            score_next = clip_one(64'(acc_reg));
                        end
                        MODE_CHISQ, MODE_ABSOLUTE:
                        begin
                            score_next = (acc_reg >= 48'(ONE_Q)) ? '0
                                       : ONE_Q - acc_reg[BIN_W-1:0];
                        end
                        MODE_EUCLID:
                        begin
                            div_req.start    = 1'b1;
                            div_req.rem_init = '0;
                            div_req.num_init = {eu_num, 15'd0};
                            div_req.den      = 64'(cnt_reg);
                            div_req.iters    = 7'd49;
                            state_next       = S_FDIVW;
                        end
                        default:
                        begin
                            if ((ee_reg != '0) && (oo_reg != '0))
                            begin
                                sqrt_req.start = 1'b1;
                                sqrt_req.value = {2'b00, ee_reg, 14'd0};
                                state_next     = S_CSQ1;
                            end
                        end
                    endcase
                end
            end
            S_FDIVW:
            begin
                if (div_rsp.done)
                begin
                    if (mode_reg == MODE_EUCLID)
                    begin
                        sqrt_req.start = 1'b1;
                        sqrt_req.value = div_rsp.quot;
                        state_next     = S_ESQW;
                    end
                    else
                    begin
                        score_next = clip_one(div_rsp.quot);
                        state_next = S_DONE;
                    end
                end
            end
            S_ESQW:
            begin
                if (sqrt_rsp.done)
                begin
                    score_next = clip_one(64'(sqrt_rsp.root));
                    state_next = S_DONE;
                end
            end
            S_CSQ1:
            begin
                if (sqrt_rsp.done)
                begin
                    root_next      = sqrt_rsp.root;
                    sqrt_req.start = 1'b1;
                    sqrt_req.value = {2'b00, oo_reg, 14'd0};
                    state_next     = S_CSQ2;
                end
            end
            S_CSQ2:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = S_COSM;
                end
            end
            S_COSM:
            begin
                if (64'(acc_reg) >= prod_reg)
                begin
                    score_next = ONE_Q;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = 64'(acc_reg);
                    div_req.num_init = '0;
                    div_req.den      = prod_reg;
                    div_req.iters    = 7'(FRAC_BITS + 14);
                    state_next       = S_FDIVW;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_score_next = err_reg ? '0 : score_reg;
                    out_err_next   = err_reg;
                    acc_next       = '0;
                    esum_next      = '0;
                    osum_next      = '0;
                    ee_next        = '0;
                    oo_next        = '0;
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            esum_reg      <= '0;
            osum_reg      <= '0;
            ee_reg        <= '0;
            oo_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            esum_reg      <= esum_next;
            osum_reg      <= osum_next;
            ee_reg        <= ee_next;
            oo_reg        <= oo_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg         <= e_next;
        o_reg         <= o_next;
        last_reg      <= last_next;
        term_reg      <= term_next;
        lgn_reg       <= lgn_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        lnm_reg       <= lnm_next;
        net_reg       <= net_next;
        side_reg      <= side_next;
        root_reg      <= root_next;
        score_reg     <= score_next;
        err_reg       <= err_next;
        out_score_reg <= out_score_next;
        out_err_reg   <= out_err_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_score_reg};
    assign m_axis_tuser  = out_err_reg;

`ifndef SYNTHESIS
    // divider results only land where the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FDIVW || state_reg == S_CHIW))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> (state_reg == S_ESQW || state_reg == S_CSQ1 || state_reg == S_CSQ2))
        else $error("root finished outside a wait state");

    // a new bin is taken only with both iterative units quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!div_rsp.done && !sqrt_rsp.done))
        else $error("bin accepted while a unit was busy");

    // issuing a score clears the histogram state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=>
        (acc_reg == '0 && cnt_reg == '0 && m_axis_tvalid))
        else $error("state not cleared after score transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BINS))
        else $error("bin count above limit");
`endif

endmodule

@@ design/hds_log2.sv @@
`timescale 1ns / 1ps
module hds_log2
(
    input  logic [hds_pkg::LOG_IN_W-1:0]  x,
    output logic [hds_pkg::LOG_OUT_W-1:0] y
);
    import hds_pkg::*;

    logic [LOG_K_W-1:0]              k;
    logic [LOG_IN_W-1:0]             frac;
    logic [LOG_IN_W+LOG_IDX_W-1:0]   wide;
    logic [LOG_IDX_W-1:0]            idx;

    // leading one position
    always_comb
    begin
        k = '0;
        for (int i = 1; i < LOG_IN_W; i++)
        begin
            if (x[i])
            begin
                k = LOG_K_W'(i);
            end
        end
    end

    always_comb
    begin
        frac = x & ~(LOG_IN_W'(1) << k);
        wide = {frac, {LOG_IDX_W{1'b0}}} >> k;
        idx  = wide[LOG_IDX_W-1:0];
        y    = {k, {LOG_FB{1'b0}}} + LOG_OUT_W'(LOG_ROM[idx]);
    end

endmodule

@@ design/hds_div.sv @@
`timescale 1ns / 1ps
module hds_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  hds_pkg::div_req_t req,
    output hds_pkg::div_rsp_t rsp
);
    import hds_pkg::*;

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] quot_reg, quot_next;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    // restoring step: shift in one numerator bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[63]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            num_next  = req.num_init;
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next  = cnt_reg - 7'd1;
                rem_next  = ge ? diff[63:0] : trial[63:0];
                num_next  = {num_reg[62:0], 1'b0};
                quot_next = {quot_reg[62:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = busy_reg && (cnt_reg == 7'd0);
    assign rsp.quot = quot_reg;

endmodule

@@ design/hds_sqrt.sv @@
`timescale 1ns / 1ps
module hds_sqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  hds_pkg::sqrt_req_t req,
    output hds_pkg::sqrt_rsp_t rsp
);
    import hds_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] val_reg, val_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            val_next  = req.value;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                bit_next = bit_reg >> 2;
                if (val_reg >= trial)
                begin
                    val_next = val_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = busy_reg && (cnt_reg == 6'd0);
    assign rsp.root = res_reg[31:0];

endmodule
